[sv/serial_led_command_frame_parser_unit_macros.svh]
// Assertion macros shared by the serial LED command frame parser RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef SERIAL_LED_COMMAND_FRAME_PARSER_UNIT_MACROS_SVH
`define SERIAL_LED_COMMAND_FRAME_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLCFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slcfp same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SLCFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slcfp next-cycle check failed");

`endif

[sv/slcfp_pkg.sv]
// Package for the serial LED command frame parser.
// Holds frame constants, byte positions, status codes and the result struct.
package slcfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'hAA;
  localparam logic [7:0] CMD_LED    = 8'h06;
  localparam logic [7:0] SWITCH_OFF = 8'h00;

  typedef logic [2:0] frame_pos_t;

  localparam frame_pos_t POS_HDR1 = 3'd0;
  localparam frame_pos_t POS_HDR2 = 3'd1;
  localparam frame_pos_t POS_LEN  = 3'd2;
  localparam frame_pos_t POS_CMD  = 3'd3;
  localparam frame_pos_t POS_LED  = 3'd4;
  localparam frame_pos_t POS_SW   = 3'd5;
  localparam frame_pos_t POS_SUM  = 3'd6;
  localparam frame_pos_t POS_NONE = 3'd7;

  typedef enum logic [1:0] {
    FS_LED_OK  = 2'd0,
    FS_BAD_SUM = 2'd1,
    FS_OTHER   = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic          hit;
    frame_status_t status;
    logic [7:0]    led_index;
    logic          led_lit;
  } frame_result_t;

endpackage

[sv/slcfp_core.sv]
// Frame hunt and checksum core: keeps byte position, running XOR and fields.
// Depends on slcfp_pkg and the assertion macro header.
`include "serial_led_command_frame_parser_unit_macros.svh"

module slcfp_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  output slcfp_pkg::frame_result_t result
);
  import slcfp_pkg::*;

  frame_pos_t pos_r, pos_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] led_r, led_nxt;
  logic [7:0] sw_r, sw_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HDR1;
      xor_r <= '0;
      cmd_r <= '0;
      led_r <= '0;
      sw_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      xor_r <= xor_nxt;
      cmd_r <= cmd_nxt;
      led_r <= led_nxt;
      sw_r  <= sw_nxt;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    xor_nxt = xor_r;
    cmd_nxt = cmd_r;
    led_nxt = led_r;
    sw_nxt  = sw_r;
    result  = '0;
    if (step) begin
      unique case (pos_r) inside
        POS_HDR2: begin
          if (rx_byte == HDR_SECOND) begin
            xor_nxt = xor_r ^ rx_byte;
            pos_nxt = POS_LEN;
          end else begin
            pos_nxt = POS_HDR1;
          end
        end
        POS_LEN, POS_CMD, POS_LED, POS_SW: begin
          xor_nxt = xor_r ^ rx_byte;
          pos_nxt = pos_r + 3'd1;
          if (pos_r == POS_CMD) cmd_nxt = rx_byte;
          if (pos_r == POS_LED) led_nxt = rx_byte;
          if (pos_r == POS_SW)  sw_nxt  = rx_byte;
        end
        POS_SUM: begin
          pos_nxt    = POS_HDR1;
          result.hit = 1'b1;
          if (xor_r != rx_byte) begin
            result.status = FS_BAD_SUM;
          end else if (cmd_r == CMD_LED) begin
            result.status    = FS_LED_OK;
            result.led_index = led_r;
            result.led_lit   = (sw_r != SWITCH_OFF);
          end else begin
            result.status = FS_OTHER;
          end
        end
        default: begin
          if (rx_byte == HDR_FIRST) begin
            xor_nxt = rx_byte;
            pos_nxt = POS_HDR2;
          end else begin
            pos_nxt = POS_HDR1;
          end
        end
      endcase
    end
  end

  `SLCFP_ASSERT_IMP(a_pos_reachable, 1'b1, pos_r != POS_NONE)
  `SLCFP_ASSERT_IMP(a_hit_only_at_sum, result.hit, step && pos_r == POS_SUM)
  `SLCFP_ASSERT_NXT(a_sum_restarts, step && pos_r == POS_SUM, pos_r == POS_HDR1)

endmodule

[sv/serial_led_command_frame_parser_unit.sv]
// Serial LED command frame parser: one received byte per cycle, one result per frame.
// Bytes wait in the input register; a frame's result is held in the result register.
// Throughput: one byte per cycle; the input register advances whenever the result
// register is empty or being taken, so stalls only come from out_ready.
// Reset (rst_n low, synchronous) empties both registers and restarts the header hunt.
// Depends on slcfp_pkg, slcfp_core and the assertion macro header.
`include "serial_led_command_frame_parser_unit_macros.svh"

module serial_led_command_frame_parser_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_frame_status,
  output logic [7:0] out_led_index,
  output logic       out_led_lit
);
  import slcfp_pkg::*;

  logic          s1_valid_r, s1_valid_nxt;
  logic [7:0]    s1_byte_r, s1_byte_nxt;
  logic          out_valid_r, out_valid_nxt;
  frame_result_t out_res_r, out_res_nxt;
  logic          s1_adv;
  frame_result_t core_res;

  slcfp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .rx_byte (s1_byte_r),
    .result  (core_res)
  );

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_byte_nxt   = s1_byte_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
      s1_byte_nxt  = in_rx_byte;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = core_res.hit;
      if (core_res.hit) out_res_nxt = core_res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_frame_status = out_res_r.status;
  assign out_led_index    = out_res_r.led_index;
  assign out_led_lit      = out_res_r.led_lit;

  `SLCFP_ASSERT_NXT(a_s1_holds, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_byte_r))
  `SLCFP_ASSERT_IMP(a_full_blocks_input, s1_valid_r && !s1_adv, !in_ready)
  `SLCFP_ASSERT_IMP(a_non_led_zero, out_valid_r && out_res_r.status != FS_LED_OK,
                    out_res_r.led_index == 8'd0 && !out_res_r.led_lit)

endmodule
